/* sv/q4sg_pkg.sv */
// ----------------------------------------------------------------------------
// q4sg_pkg
// Shared types, widths and helpers of the Q4 global shape gradient unit.
// ----------------------------------------------------------------------------
package q4sg_pkg;

   // Element geometry
   localparam int DIMENSIONS = 2;
   localparam int CORNERS    = 4;
   localparam int LANES      = CORNERS * DIMENSIONS;

   // Fixed-point formats
   localparam int FRAC_BITS  = 16;
   localparam int G_FRAC     = 16;
   localparam int NAT_ONE    = 16384;
   localparam int QUOT_SHIFT = 2 * FRAC_BITS - G_FRAC;

   // Datapath widths
   localparam int NAT_W  = 16;
   localparam int POS_W  = 32;
   localparam int G_W    = NAT_W + 2;
   localparam int PROD_W = POS_W + G_W;
   localparam int JSUM_W = PROD_W + 2;
   localparam int JAC_W  = 32;
   localparam int DETP_W = 2 * JAC_W;
   localparam int DET_W  = DETP_W;
   localparam int NUMP_W = JAC_W + G_W;
   localparam int NUM_W  = NUMP_W + 1;
   localparam int N_W    = NUM_W + QUOT_SHIFT;
   localparam int D_W    = DET_W;
   localparam int GRAD_W = 32;
   localparam int Q_BITS = GRAD_W;
   localparam int WK_W   = (N_W > D_W + Q_BITS) ? N_W + 1 : D_W + Q_BITS + 1;
   localparam int J_MAX  = 2 ** (JAC_W - 1) - 1;

   // Pipeline depth
   localparam int PRE_STAGES = 6;
   localparam int DIV_STAGES = Q_BITS + 1;
   localparam int PIPE_DEPTH = PRE_STAGES + DIV_STAGES;

   typedef struct packed {
      logic signed [NAT_W-1:0] xi;
      logic signed [NAT_W-1:0] eta;
      logic signed [POS_W-1:0] node0_x;
      logic signed [POS_W-1:0] node0_y;
      logic signed [POS_W-1:0] node1_x;
      logic signed [POS_W-1:0] node1_y;
      logic signed [POS_W-1:0] node2_x;
      logic signed [POS_W-1:0] node2_y;
      logic signed [POS_W-1:0] node3_x;
      logic signed [POS_W-1:0] node3_y;
   } req_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad0_x;
      logic signed [GRAD_W-1:0] grad0_y;
      logic signed [GRAD_W-1:0] grad1_x;
      logic signed [GRAD_W-1:0] grad1_y;
      logic signed [GRAD_W-1:0] grad2_x;
      logic signed [GRAD_W-1:0] grad2_y;
      logic signed [GRAD_W-1:0] grad3_x;
      logic signed [GRAD_W-1:0] grad3_y;
      logic                     singular;
   } rsp_type;

   // Per-lane divider control
   typedef struct packed {
      logic neg;
      logic ovf;
      logic zero;
   } div_ctl_type;

   // One divider stage word: partial remainder, divisor, quotient so far
   typedef struct packed {
      logic [N_W-1:0]    rem;
      logic [D_W-1:0]    den;
      logic [Q_BITS-1:0] quo;
      div_ctl_type       ctl;
   } div_word_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] result;
      logic                     zero;
   } div_out_type;

   // Round a Jacobian sum to nearest (half up), then clamp symmetrically
   function automatic logic signed [JAC_W-1:0] jac_round_sat(
      input logic signed [JSUM_W-1:0] s
   );
      logic signed [JSUM_W-1:0] r;
      r = s + $signed(JSUM_W'(1) << (G_FRAC - 1));
      r = r >>> G_FRAC;
      if (r > $signed(JSUM_W'(J_MAX))) begin
         r = $signed(JSUM_W'(J_MAX));
      end else if (r < -$signed(JSUM_W'(J_MAX))) begin
         r = -$signed(JSUM_W'(J_MAX));
      end
      return JAC_W'(r);
   endfunction

endpackage

/* sv/q4sg_div.sv */
// ----------------------------------------------------------------------------
// q4sg_div
// Pipelined restoring divider for one gradient lane: one quotient bit per
// stage, then round to nearest (ties away), sign and saturate.
// ----------------------------------------------------------------------------
module q4sg_div (
   input  logic                   clock,
   input  logic                   en,
   input  q4sg_pkg::div_word_type div_in,
   output q4sg_pkg::div_out_type  div_out
);
   import q4sg_pkg::*;

   div_word_type st_w    [Q_BITS+1];
   div_word_type step_in [Q_BITS];
   div_word_type step_ff [Q_BITS];

   div_out_type      res_in;
   div_out_type      res_ff;
   logic [WK_W-1:0]  rnd_lhs;
   logic [WK_W-1:0]  rnd_rhs;
   logic             rnd;
   logic [Q_BITS:0]  qf;

   assign st_w[0] = div_in;

   for (genvar k = 0; k < Q_BITS; k++) begin : g_step
      localparam int SH = Q_BITS - 1 - k;
      logic [WK_W-1:0] rem_w;
      logic [WK_W-1:0] den_w;

      // Try subtracting the shifted divisor, keep the result if it fits
      always_comb begin
         rem_w      = WK_W'(st_w[k].rem);
         den_w      = WK_W'(st_w[k].den) << SH;
         step_in[k] = st_w[k];
         if (rem_w >= den_w) begin
            step_in[k].rem = N_W'(rem_w - den_w);
            step_in[k].quo = {st_w[k].quo[Q_BITS-2:0], 1'b1};
         end else begin
            step_in[k].quo = {st_w[k].quo[Q_BITS-2:0], 1'b0};
         end
      end

      // Advance the stage
      always_ff @(posedge clock) begin
         if (en) begin
            step_ff[k] <= step_in[k];
         end
      end

      assign st_w[k+1] = step_ff[k];
   end

   // Round on the remainder, then sign and saturate
   always_comb begin
      rnd_lhs = WK_W'({st_w[Q_BITS].rem, 1'b0});
      rnd_rhs = WK_W'(st_w[Q_BITS].den);
      rnd     = (rnd_lhs >= rnd_rhs);
      qf      = {1'b0, st_w[Q_BITS].quo} + (Q_BITS+1)'(rnd);
      res_in.zero = st_w[Q_BITS].ctl.zero;
      if (st_w[Q_BITS].ctl.zero) begin
         res_in.result = '0;
      end else if (!st_w[Q_BITS].ctl.neg) begin
         if (st_w[Q_BITS].ctl.ovf || qf > (Q_BITS+1)'(J_MAX)) begin
            res_in.result = GRAD_W'(J_MAX);
         end else begin
            res_in.result = GRAD_W'(qf);
         end
      end else begin
         if (st_w[Q_BITS].ctl.ovf || qf > ((Q_BITS+1)'(1) << (GRAD_W - 1))) begin
            res_in.result = GRAD_W'(1) << (GRAD_W - 1);
         end else begin
            res_in.result = GRAD_W'((Q_BITS+1)'(0) - qf);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign div_out = res_ff;

endmodule

/* sv/q4_global_shape_gradient_unit.sv */
// ----------------------------------------------------------------------------
// q4_global_shape_gradient_unit
// Throughput: one word per cycle while req_stall is low; the 32-step divider
// pipeline and the six front stages each take a new word every unstalled cycle.
// A two-entry output (register plus skid) decouples rsp_stall from req_stall.
// Reset clears all valid bits, including those of the output slots; data is not reset.
// ----------------------------------------------------------------------------
module q4_global_shape_gradient_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  q4sg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output q4sg_pkg::rsp_type rsp_data
);
   import q4sg_pkg::*;

   logic en;
   logic take;

   logic [PIPE_DEPTH-1:0] v_in;
   logic [PIPE_DEPTH-1:0] v_ff;

   req_type s1_req_ff;

   logic signed [POS_W-1:0]  pos [CORNERS][DIMENSIONS];
   logic signed [G_W-1:0]    g   [CORNERS][DIMENSIONS];
   logic signed [G_W-1:0]    nme, npe, nmx, npx, nat;

   logic signed [PROD_W-1:0] s2_prod_in [DIMENSIONS][DIMENSIONS][CORNERS];
   logic signed [PROD_W-1:0] s2_prod_ff [DIMENSIONS][DIMENSIONS][CORNERS];
   logic signed [G_W-1:0]    s2_g_ff    [CORNERS][DIMENSIONS];

   logic signed [JSUM_W-1:0] jsum;
   logic signed [JAC_W-1:0]  s3_jac_in  [DIMENSIONS][DIMENSIONS];
   logic signed [JAC_W-1:0]  s3_jac_ff  [DIMENSIONS][DIMENSIONS];
   logic signed [G_W-1:0]    s3_g_ff    [CORNERS][DIMENSIONS];

   logic signed [DETP_W-1:0] s4_detp_in [2];
   logic signed [DETP_W-1:0] s4_detp_ff [2];
   logic signed [NUMP_W-1:0] s4_nump_in [CORNERS][DIMENSIONS][2];
   logic signed [NUMP_W-1:0] s4_nump_ff [CORNERS][DIMENSIONS][2];

   logic signed [DET_W-1:0]  s5_det_in;
   logic signed [DET_W-1:0]  s5_det_ff;
   logic signed [NUM_W-1:0]  s5_num_in  [CORNERS][DIMENSIONS];
   logic signed [NUM_W-1:0]  s5_num_ff  [CORNERS][DIMENSIONS];

   logic [D_W-1:0]    ud;
   logic [NUM_W-1:0]  un;
   logic [N_W-1:0]    nsh;
   div_word_type      s6_lane_in [LANES];
   div_word_type      s6_lane_ff [LANES];
   div_out_type       lane_out   [LANES];

   rsp_type last_w;
   rsp_type out_in, out_ff, sk_in, sk_ff;
   logic    out_v_in, out_v_ff, sk_v_in, sk_v_ff;

   // Hold the whole pipe only when the skid slot is occupied
   assign en        = !sk_v_ff;
   assign req_stall = sk_v_ff;
   assign take      = out_v_ff && !rsp_stall;

   // Advance valid bits alongside the data
   assign v_in = {v_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // Stage 1: capture the input word
   always_ff @(posedge clock) begin
      if (en) begin
         s1_req_ff <= req_data;
      end
   end

   // Stage 2: reference gradients and corner-by-gradient products
   always_comb begin
      pos[0][0] = s1_req_ff.node0_x;  pos[0][1] = s1_req_ff.node0_y;
      pos[1][0] = s1_req_ff.node1_x;  pos[1][1] = s1_req_ff.node1_y;
      pos[2][0] = s1_req_ff.node2_x;  pos[2][1] = s1_req_ff.node2_y;
      pos[3][0] = s1_req_ff.node3_x;  pos[3][1] = s1_req_ff.node3_y;
      nat = G_W'(NAT_ONE);
      nme = nat - G_W'(s1_req_ff.eta);
      npe = nat + G_W'(s1_req_ff.eta);
      nmx = nat - G_W'(s1_req_ff.xi);
      npx = nat + G_W'(s1_req_ff.xi);
      g[0][0] = -nme;  g[0][1] = -nmx;
      g[1][0] =  nme;  g[1][1] = -npx;
      g[2][0] =  npe;  g[2][1] =  npx;
      g[3][0] = -npe;  g[3][1] =  nmx;
      for (int i = 0; i < DIMENSIONS; i++) begin
         for (int k = 0; k < DIMENSIONS; k++) begin
            for (int c = 0; c < CORNERS; c++) begin
               s2_prod_in[i][k][c] = PROD_W'(pos[c][i]) * PROD_W'(g[c][k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_prod_ff <= s2_prod_in;
         s2_g_ff    <= g;
      end
   end

   // Stage 3: sum over corners, round and clamp the Jacobian
   always_comb begin
      jsum = '0;
      for (int i = 0; i < DIMENSIONS; i++) begin
         for (int k = 0; k < DIMENSIONS; k++) begin
            jsum = '0;
            for (int c = 0; c < CORNERS; c++) begin
               jsum = jsum + JSUM_W'(s2_prod_ff[i][k][c]);
            end
            s3_jac_in[i][k] = jac_round_sat(jsum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_jac_ff <= s3_jac_in;
         s3_g_ff   <= s2_g_ff;
      end
   end

   // Stage 4: determinant and numerator products
   always_comb begin
      s4_detp_in[0] = DETP_W'(s3_jac_ff[0][0]) * DETP_W'(s3_jac_ff[1][1]);
      s4_detp_in[1] = DETP_W'(s3_jac_ff[0][1]) * DETP_W'(s3_jac_ff[1][0]);
      for (int c = 0; c < CORNERS; c++) begin
         s4_nump_in[c][0][0] = NUMP_W'(s3_jac_ff[1][1]) * NUMP_W'(s3_g_ff[c][0]);
         s4_nump_in[c][0][1] = NUMP_W'(s3_jac_ff[1][0]) * NUMP_W'(s3_g_ff[c][1]);
         s4_nump_in[c][1][0] = NUMP_W'(s3_jac_ff[0][0]) * NUMP_W'(s3_g_ff[c][1]);
         s4_nump_in[c][1][1] = NUMP_W'(s3_jac_ff[0][1]) * NUMP_W'(s3_g_ff[c][0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_detp_ff <= s4_detp_in;
         s4_nump_ff <= s4_nump_in;
      end
   end

   // Stage 5: determinant and numerators
   always_comb begin
      s5_det_in = s4_detp_ff[0] - s4_detp_ff[1];
      for (int c = 0; c < CORNERS; c++) begin
         for (int d = 0; d < DIMENSIONS; d++) begin
            s5_num_in[c][d] = NUM_W'(s4_nump_ff[c][d][0]) - NUM_W'(s4_nump_ff[c][d][1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_det_ff <= s5_det_in;
         s5_num_ff <= s5_num_in;
      end
   end

   // Stage 6: magnitudes, sign, overflow and singular checks per lane
   always_comb begin
      ud  = s5_det_ff[DET_W-1] ? D_W'(-s5_det_ff) : D_W'(s5_det_ff);
      un  = '0;
      nsh = '0;
      for (int c = 0; c < CORNERS; c++) begin
         for (int d = 0; d < DIMENSIONS; d++) begin
            un  = s5_num_ff[c][d][NUM_W-1] ? NUM_W'(-s5_num_ff[c][d])
                                           : NUM_W'(s5_num_ff[c][d]);
            nsh = N_W'(un) << QUOT_SHIFT;
            s6_lane_in[c*DIMENSIONS+d].rem      = nsh;
            s6_lane_in[c*DIMENSIONS+d].den      = ud;
            s6_lane_in[c*DIMENSIONS+d].quo      = '0;
            s6_lane_in[c*DIMENSIONS+d].ctl.neg  =
               s5_num_ff[c][d][NUM_W-1] ^ s5_det_ff[DET_W-1];
            s6_lane_in[c*DIMENSIONS+d].ctl.ovf  =
               (WK_W'(nsh >> Q_BITS) >= WK_W'(ud));
            s6_lane_in[c*DIMENSIONS+d].ctl.zero = (ud == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_lane_ff <= s6_lane_in;
      end
   end

   // Divider lanes
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      q4sg_div u_div (
         .clock   (clock),
         .en      (en),
         .div_in  (s6_lane_ff[l]),
         .div_out (lane_out[l])
      );
   end

   // Gather the lane results into one word
   always_comb begin
      last_w.grad0_x  = lane_out[0].result;
      last_w.grad0_y  = lane_out[1].result;
      last_w.grad1_x  = lane_out[2].result;
      last_w.grad1_y  = lane_out[3].result;
      last_w.grad2_x  = lane_out[4].result;
      last_w.grad2_y  = lane_out[5].result;
      last_w.grad3_x  = lane_out[6].result;
      last_w.grad3_y  = lane_out[7].result;
      last_w.singular = lane_out[0].zero;
   end

   // Output register with skid slot: drain skid first, else take the pipe
   always_comb begin
      out_in   = out_ff;
      out_v_in = out_v_ff;
      sk_in    = sk_ff;
      sk_v_in  = sk_v_ff;
      if (take) begin
         out_v_in = 1'b0;
      end
      if (!out_v_ff || take) begin
         if (sk_v_ff) begin
            out_in   = sk_ff;
            out_v_in = 1'b1;
            sk_v_in  = 1'b0;
         end else if (en && v_ff[PIPE_DEPTH-1]) begin
            out_in   = last_w;
            out_v_in = 1'b1;
         end
      end else if (en && v_ff[PIPE_DEPTH-1]) begin
         sk_in   = last_w;
         sk_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sk_ff  <= sk_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

/* sv/q4sg_checker.sv */
// ----------------------------------------------------------------------------
// q4sg_checker
// Port-level checks of the Q4 global shape gradient unit, bound to the top.
// ----------------------------------------------------------------------------
module q4sg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input q4sg_pkg::rsp_type rsp_data
);
   import q4sg_pkg::*;

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word dropped or changed");

   // Zero every gradient of a singular element
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.grad0_x == '0 && rsp_data.grad0_y == '0 &&
         rsp_data.grad1_x == '0 && rsp_data.grad1_y == '0 &&
         rsp_data.grad2_x == '0 && rsp_data.grad2_y == '0 &&
         rsp_data.grad3_x == '0 && rsp_data.grad3_y == '0)
      else $error("singular word carries nonzero gradients");

   // Come out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("unit not empty after reset");

   // Stall the input only while a result word is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with no pending rsp word");

endmodule

bind q4_global_shape_gradient_unit q4sg_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q4 global shape gradient unit. Directed quads
// (unit square, extreme natural points, singular and saturating elements)
// are followed by random distorted quads and raw bit patterns, sent in
// bursts against a randomly stalling receiver. A scoreboard predicts every
// result word in fixed point and checks the words in order.
// ----------------------------------------------------------------------------
import q4sg_pkg::*;

class gradient_scoreboard;
   rsp_type pending_q[$];
   int      mismatches;

   // Quotient num * 2^QUOT_SHIFT / den, nearest with ties away, saturated
   function longint round_div(longint num, longint den);
      bit          neg;
      longint      an, ad;
      bit [127:0]  un, ud, q, rm;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      un  = {64'd0, an};
      ud  = {64'd0, ad};
      un  = un << QUOT_SHIFT;
      q   = un / ud;
      rm  = un - q * ud;
      if (rm * 2 >= ud) begin
         q = q + 1;
      end
      if (neg) begin
         if (q > 128'h8000_0000) return -64'sd2147483648;
         return -longint'(q[63:0]);
      end
      if (q > 128'h7fff_ffff) return 64'sd2147483647;
      return longint'(q[63:0]);
   endfunction

   // Global gradients of the four shape functions for one request word
   function rsp_type shape_gradients(req_type w);
      longint     pos[4][2];
      longint     g[4][2];
      longint     jac[2][2];
      longint     xi, eta, s, r, det, nx, ny;
      logic [31:0] gv[8];
      rsp_type    o;
      xi  = longint'(w.xi);
      eta = longint'(w.eta);
      pos[0][0] = w.node0_x; pos[0][1] = w.node0_y;
      pos[1][0] = w.node1_x; pos[1][1] = w.node1_y;
      pos[2][0] = w.node2_x; pos[2][1] = w.node2_y;
      pos[3][0] = w.node3_x; pos[3][1] = w.node3_y;
      g[0][0] = -(NAT_ONE - eta); g[0][1] = -(NAT_ONE - xi);
      g[1][0] =  (NAT_ONE - eta); g[1][1] = -(NAT_ONE + xi);
      g[2][0] =  (NAT_ONE + eta); g[2][1] =  (NAT_ONE + xi);
      g[3][0] = -(NAT_ONE + eta); g[3][1] =  (NAT_ONE - xi);
      for (int i = 0; i < 2; i++) begin
         for (int k = 0; k < 2; k++) begin
            s = 0;
            for (int c = 0; c < 4; c++) s += pos[c][i] * g[c][k];
            r = (s + 64'sd32768) >>> 16;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483647) r = -64'sd2147483647;
            jac[i][k] = r;
         end
      end
      det = jac[0][0] * jac[1][1] - jac[0][1] * jac[1][0];
      for (int c = 0; c < 4; c++) begin
         gv[2*c]   = '0;
         gv[2*c+1] = '0;
         if (det != 0) begin
            nx = jac[1][1] * g[c][0] - jac[1][0] * g[c][1];
            ny = jac[0][0] * g[c][1] - jac[0][1] * g[c][0];
            gv[2*c]   = 32'(round_div(nx, det));
            gv[2*c+1] = 32'(round_div(ny, det));
         end
      end
      o = {gv[0], gv[1], gv[2], gv[3], gv[4], gv[5], gv[6], gv[7], det == 0};
      return o;
   endfunction

   function void note_request(req_type w);
      pending_q.push_back(shape_gradients(w));
   endfunction

   // Compare one result word lane by lane against the oldest prediction
   function void check_result(rsp_type got);
      rsp_type exp_w;
      bit      bad;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result word %h", got);
         return;
      end
      exp_w = pending_q.pop_front();
      bad = (exp_w.singular !== got.singular);
      for (int j = 0; j < LANES; j++) begin
         if (exp_w[GRAD_W*LANES - GRAD_W*j -: GRAD_W] !==
             got[GRAD_W*LANES - GRAD_W*j -: GRAD_W]) bad = 1;
      end
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected %h", exp_w);
            $display("          actual   %h", got);
         end
      end
   endfunction

   function int pending();
      return pending_q.size();
   endfunction
endclass

module tb_top;
   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   gradient_scoreboard sb = new();
   bit  hold_request = 0;
   int  idle_cycles  = 0;

   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;

   q4_global_shape_gradient_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Offer one word and hold it until accepted
   task automatic send_word(req_type w);
      req_data  = w;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sb.note_request(w);
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_valid = 0;
      repeat (n) @(negedge clock);
   endtask

   // Axis-aligned quad scaled by side, corners counterclockwise from (-1,-1)
   function automatic req_type make_quad(int xi, int eta, int x0, int y0, int sx, int sy);
      req_type w;
      w.xi = 16'(xi); w.eta = 16'(eta);
      w.node0_x = x0;      w.node0_y = y0;
      w.node1_x = x0 + sx; w.node1_y = y0;
      w.node2_x = x0 + sx; w.node2_y = y0 + sy;
      w.node3_x = x0;      w.node3_y = y0 + sy;
      return w;
   endfunction

   function automatic logic [15:0] rand_nat();
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   function automatic req_type rand_word();
      req_type w;
      int      kind, side, x0, y0, jit;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         w = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      end else if (kind < 18) begin
         // collapse to a point or a line so the determinant vanishes
         w = make_quad(rand_nat(), rand_nat(), $urandom, $urandom, 0, 0);
         if (kind >= 15) begin
            w.node1_x = w.node0_x + 32'h10000; w.node2_x = w.node0_x + 32'h20000;
            w.node3_x = w.node0_x + 32'h30000;
         end
      end else begin
         side = $urandom_range(1, 1 << 22);
         x0   = $urandom_range(0, 1 << 24) - (1 << 23);
         y0   = $urandom_range(0, 1 << 24) - (1 << 23);
         jit  = side / 3 + 1;
         w = make_quad(rand_nat(), rand_nat(), x0, y0, side, $urandom_range(1, 1 << 22));
         w.node0_x += $urandom_range(0, jit) - jit / 2;
         w.node1_y += $urandom_range(0, jit) - jit / 2;
         w.node2_x += $urandom_range(0, jit) - jit / 2;
         w.node3_y += $urandom_range(0, jit) - jit / 2;
         if ($urandom_range(0, 4) == 0) w.node2_y = $urandom;
      end
      return w;
   endfunction

   // Stimulus
   initial begin
      req_type w;
      int      sent, burst;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Unit square at the center, corners and far outside the element
      send_word(make_quad(0, 0, -32'h10000, -32'h10000, 32'h20000, 32'h20000));
      send_word(make_quad(-16384, -16384, 0, 0, 32'h10000, 32'h10000));
      send_word(make_quad(16384, 16384, 0, 0, 32'h10000, 32'h20000));
      send_word(make_quad(-32768, 32767, 0, 0, 32'h10000, 32'h10000));
      send_word(make_quad(32767, -32768, 32'h100, 32'h200, 32'h30000, 32'h8000));
      // Mirrored element gives a negative determinant
      send_word(make_quad(1000, -2000, 0, 0, -32'h10000, 32'h10000));
      // Singular: all corners on one point, then all on a line
      send_word(make_quad(0, 0, 32'h12345, 32'h6789, 0, 0));
      send_word(make_quad(500, 500, 0, 0, 32'h10000, 0));
      // Tiny element: the Jacobian diagonal rounds half up to one unit
      send_word(make_quad(0, 0, 0, 0, 1, 1));
      // Huge element saturates the Jacobian
      w = make_quad(0, 0, 0, 0, 0, 0);
      w.node0_x = 32'h8000_0000; w.node0_y = 32'h8000_0000;
      w.node1_x = 32'h7fff_ffff; w.node1_y = 32'h8000_0000;
      w.node2_x = 32'h7fff_ffff; w.node2_y = 32'h7fff_ffff;
      w.node3_x = 32'h8000_0000; w.node3_y = 32'h7fff_ffff;
      send_word(w);
      w.xi = 16'h7fff; w.eta = 16'h8000;
      send_word(w);
      // Long thin sliver: large y gradients, small x gradients
      send_word(make_quad(0, 0, 0, 0, 32'h7000_0000, 2));
      w = '1; send_word(w);
      w = '0; send_word(w);
      idle_gap(3);

      sent = 0;
      while (sent < 1800) begin
         // Ask the receiver for its long hold-off once, and keep sending
         if (sent >= 600 && !hold_request) hold_request = 1;
         if (sent == 1200) begin
            idle_gap(1);
            while (sb.pending() != 0) @(negedge clock);
         end
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && sent < 1800; b++) begin
            send_word(rand_word());
            sent++;
            if (sent == 1200) break;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
      req_valid = 0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (60) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Receiver stall pattern, with stall-free windows and one long hold-off
   initial begin
      logic [15:0] pattern;
      int          mode;
      bit          held;
      pattern = '0;
      mode    = 0;
      held    = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !held) begin
            rsp_stall = 1;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1;
         end
         if ($urandom_range(0, 63) == 0) begin
            pattern = 16'($urandom);
            mode    = $urandom_range(0, 3);
         end
         pattern   = {pattern[14:0], pattern[15]};
         rsp_stall = (mode != 0) && pattern[0];
      end
   end

   // Check accepted results and watch for a hang
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end
endmodule
